@@ rtl/core/rvex_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared types and constants of the RV32IM execute unit.
// ----------------------------------------------------------------------------
package rvex_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] KIND_DONE    = 3'd0;
    localparam logic [2:0] KIND_LOAD    = 3'd1;
    localparam logic [2:0] KIND_STORE   = 3'd2;
    localparam logic [2:0] KIND_SYSTEM  = 3'd3;
    localparam logic [2:0] KIND_ILLEGAL = 3'd4;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [31:0] UPPER_MASK = 32'hfffff000;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT = 7'h20;

    localparam logic [1:0] CMP_EQ  = 2'd0;
    localparam logic [1:0] CMP_LT  = 2'd2;
    localparam logic [1:0] CMP_LTU = 2'd3;

    typedef enum logic [4:0] {
        FN_ADD    = 5'd0,
        FN_SUB    = 5'd1,
        FN_SLL    = 5'd2,
        FN_SLT    = 5'd3,
        FN_SLTU   = 5'd4,
        FN_XOR    = 5'd5,
        FN_SRL    = 5'd6,
        FN_SRA    = 5'd7,
        FN_OR     = 5'd8,
        FN_AND    = 5'd9,
        FN_MUL    = 5'd10,
        FN_MULH   = 5'd11,
        FN_MULHSU = 5'd12,
        FN_MULHU  = 5'd13,
        FN_DIV    = 5'd14,
        FN_DIVU   = 5'd15,
        FN_REM    = 5'd16,
        FN_REMU   = 5'd17
    } fn_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  rd;
        logic        wr;
        fn_t         fn;
        logic [31:0] op_a;
        logic [31:0] op_b;
        logic        link_sel;
        logic [31:0] link;
        logic [31:0] seq_pc;
        logic [31:0] target;
        logic        jump;
        logic        branch;
        logic [2:0]  br_f3;
        logic        is_mem;
        logic [1:0]  mem_size;
        logic        load_signed;
        logic [31:0] store_data;
    } op_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        write_enable;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic [31:0] next_pc;
        logic        branch_taken;
        logic [31:0] mem_address;
        logic [1:0]  mem_size;
        logic        load_signed;
        logic [31:0] store_data;
    } result_t;

endpackage

@@ rtl/core/rvex_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvex_front
// Decodes one instruction into operands, a function code and control.
// ----------------------------------------------------------------------------
module rvex_front
    import rvex_pkg::*;
(
    input  logic [31:0] instruction,
    input  logic [31:0] rs1_value,
    input  logic [31:0] rs2_value,
    input  logic [31:0] current_pc,
    output op_t         op
);

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] immi;
    logic [31:0] imms;
    logic [31:0] immb;
    logic [31:0] immj;
    logic [31:0] immu;
    logic [31:0] jalr_sum;
    logic        bad;

    assign opc  = instruction[6:0];
    assign rd   = instruction[11:7];
    assign f3   = instruction[14:12];
    assign f7   = instruction[31:25];
    assign immi = {{20{instruction[31]}}, instruction[31:20]};
    assign imms = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign immb = {{20{instruction[31]}}, instruction[7], instruction[30:25],
                   instruction[11:8], 1'b0};
    assign immj = {{12{instruction[31]}}, instruction[19:12], instruction[20],
                   instruction[30:21], 1'b0};
    assign immu = instruction & UPPER_MASK;
    assign jalr_sum = rs1_value + immi;

    always_comb
    begin
        op = '0;
        op.kind = KIND_DONE;
        op.fn = FN_ADD;
        op.link = current_pc + 32'd4;
        op.seq_pc = current_pc + 32'd4;
        op.br_f3 = f3;
        bad = 1'b0;
        case (opc)
            OP_LUI:
            begin
                op.wr = 1'b1;
                op.op_b = immu;
            end
            OP_AUIPC:
            begin
                op.wr = 1'b1;
                op.op_a = current_pc;
                op.op_b = immu;
            end
            OP_JAL:
            begin
                op.wr = 1'b1;
                op.link_sel = 1'b1;
                op.jump = 1'b1;
                op.target = current_pc + immj;
            end
            OP_JALR:
            begin
                if (f3 != 3'd0)
                begin
                    bad = 1'b1;
                end
                op.wr = 1'b1;
                op.link_sel = 1'b1;
                op.jump = 1'b1;
                op.target = {jalr_sum[31:1], 1'b0};
            end
            OP_BRANCH:
            begin
                if (f3[2:1] == 2'd1)
                begin
                    bad = 1'b1;
                end
                op.branch = 1'b1;
                op.op_a = rs1_value;
                op.op_b = rs2_value;
                op.target = current_pc + immb;
            end
            OP_LOAD:
            begin
                if (f3 == 3'd3 || f3 > 3'd5)
                begin
                    bad = 1'b1;
                end
                op.kind = KIND_LOAD;
                op.is_mem = 1'b1;
                op.op_a = rs1_value;
                op.op_b = immi;
                op.mem_size = f3[1:0];
                op.load_signed = (f3 < 3'd2);
            end
            OP_STORE:
            begin
                if (f3 > 3'd2)
                begin
                    bad = 1'b1;
                end
                op.kind = KIND_STORE;
                op.is_mem = 1'b1;
                op.op_a = rs1_value;
                op.op_b = imms;
                op.mem_size = f3[1:0];
                op.store_data = rs2_value;
            end
            OP_IMM:
            begin
                op.wr = 1'b1;
                op.op_a = rs1_value;
                op.op_b = immi;
                case (f3)
                    3'd0: op.fn = FN_ADD;
                    3'd1:
                    begin
                        op.fn = FN_SLL;
                        bad = (f7 != F7_BASE);
                    end
                    3'd2: op.fn = FN_SLT;
                    3'd3: op.fn = FN_SLTU;
                    3'd4: op.fn = FN_XOR;
                    3'd5:
                    begin
                        op.fn = f7[5] ? FN_SRA : FN_SRL;
                        bad = (f7 != F7_BASE) && (f7 != F7_ALT);
                    end
                    3'd6: op.fn = FN_OR;
                    default: op.fn = FN_AND;
                endcase
            end
            OP_REG:
            begin
                op.wr = 1'b1;
                op.op_a = rs1_value;
                op.op_b = rs2_value;
                if (f7 == F7_MULDIV)
                begin
                    case (f3)
                        3'd0: op.fn = FN_MUL;
                        3'd1: op.fn = FN_MULH;
                        3'd2: op.fn = FN_MULHSU;
                        3'd3: op.fn = FN_MULHU;
                        3'd4: op.fn = FN_DIV;
                        3'd5: op.fn = FN_DIVU;
                        3'd6: op.fn = FN_REM;
                        default: op.fn = FN_REMU;
                    endcase
                end
                else if (f7 == F7_ALT)
                begin
                    case (f3)
                        3'd0: op.fn = FN_SUB;
                        3'd5: op.fn = FN_SRA;
                        default: bad = 1'b1;
                    endcase
                end
                else if (f7 == F7_BASE)
                begin
                    case (f3)
                        3'd0: op.fn = FN_ADD;
                        3'd1: op.fn = FN_SLL;
                        3'd2: op.fn = FN_SLT;
                        3'd3: op.fn = FN_SLTU;
                        3'd4: op.fn = FN_XOR;
                        3'd5: op.fn = FN_SRL;
                        3'd6: op.fn = FN_OR;
                        default: op.fn = FN_AND;
                    endcase
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            OP_SYSTEM:
            begin
                op.kind = KIND_SYSTEM;
                op.seq_pc = current_pc;
            end
            default: bad = 1'b1;
        endcase

        if (bad)
        begin
            op.kind = KIND_ILLEGAL;
            op.seq_pc = current_pc;
            op.wr = 1'b0;
            op.fn = FN_ADD;
            op.jump = 1'b0;
            op.branch = 1'b0;
            op.is_mem = 1'b0;
            op.mem_size = 2'd0;
            op.load_signed = 1'b0;
            op.store_data = 32'd0;
        end
        if (rd == 5'd0)
        begin
            op.wr = 1'b0;
        end
        op.rd = (op.kind == KIND_DONE || op.kind == KIND_LOAD) ? rd : 5'd0;
    end

endmodule

@@ rtl/core/rvex_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvex_queue
// Small register queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
module rvex_queue
    import rvex_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  op_t  in_op,
    output logic out_valid,
    input  logic out_ready,
    output op_t  out_op
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    op_t           entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_op    = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

@@ rtl/core/rvex_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvex_back
// Executes decoded items: combinational ALU, registered multiply and
// bit-serial divide, with a registered result.
// ----------------------------------------------------------------------------
module rvex_back
    import rvex_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  op_t     in_op,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    typedef enum logic [3:0] {
        ST_RUN = 4'b0001,
        ST_MUL = 4'b0010,
        ST_DIV = 4'b0100,
        ST_FIN = 4'b1000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    op_t         cur_reg;
    logic [63:0] prod_reg;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [31:0] quo_reg;
    logic [31:0] quo_next;
    logic [31:0] divisor_reg;
    logic [4:0]  cnt_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        out_free;
    logic        is_mul;
    logic        is_div;
    logic        div_signed;
    logic [31:0] alu_value;
    logic [31:0] mul_value;
    logic [31:0] div_value;
    logic [32:0] trial;
    logic [32:0] trial_sub;

    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_RUN) && out_free;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    assign is_mul = (in_op.fn == FN_MUL) || (in_op.fn == FN_MULH) ||
                    (in_op.fn == FN_MULHSU) || (in_op.fn == FN_MULHU);
    assign is_div = (in_op.fn == FN_DIV) || (in_op.fn == FN_DIVU) ||
                    (in_op.fn == FN_REM) || (in_op.fn == FN_REMU);
    assign div_signed = (in_op.fn == FN_DIV) || (in_op.fn == FN_REM);

    always_comb
    begin
        case (in_op.fn)
            FN_SUB:  alu_value = in_op.op_a - in_op.op_b;
            FN_SLL:  alu_value = in_op.op_a << in_op.op_b[4:0];
            FN_SLT:  alu_value = {31'd0, $signed(in_op.op_a) < $signed(in_op.op_b)};
            FN_SLTU: alu_value = {31'd0, in_op.op_a < in_op.op_b};
            FN_XOR:  alu_value = in_op.op_a ^ in_op.op_b;
            FN_SRL:  alu_value = in_op.op_a >> in_op.op_b[4:0];
            FN_SRA:  alu_value = 32'($signed(in_op.op_a) >>> in_op.op_b[4:0]);
            FN_OR:   alu_value = in_op.op_a | in_op.op_b;
            FN_AND:  alu_value = in_op.op_a & in_op.op_b;
            default: alu_value = in_op.op_a + in_op.op_b;
        endcase
    end

    always_comb
    begin
        case (cur_reg.fn)
            FN_MUL: mul_value = prod_reg[31:0];
            FN_MULH: mul_value = prod_reg[63:32]
                                 - (cur_reg.op_a[31] ? cur_reg.op_b : 32'd0)
                                 - (cur_reg.op_b[31] ? cur_reg.op_a : 32'd0);
            FN_MULHSU: mul_value = prod_reg[63:32]
                                   - (cur_reg.op_a[31] ? cur_reg.op_b : 32'd0);
            default: mul_value = prod_reg[63:32];
        endcase
    end

    always_comb
    begin
        case (cur_reg.fn)
            FN_DIV:
            begin
                if (cur_reg.op_b == 32'd0)
                begin
                    div_value = 32'hffffffff;
                end
                else
                begin
                    div_value = (cur_reg.op_a[31] ^ cur_reg.op_b[31]) ? -quo_reg : quo_reg;
                end
            end
            FN_REM:  div_value = cur_reg.op_a[31] ? -rem_reg : rem_reg;
            FN_REMU: div_value = rem_reg;
            default: div_value = quo_reg;
        endcase
    end

    assign trial     = {rem_reg, quo_reg[31]};
    assign trial_sub = trial - {1'b0, divisor_reg};

    always_comb
    begin
        if (!trial_sub[32])
        begin
            rem_next = trial_sub[31:0];
            quo_next = {quo_reg[30:0], 1'b1};
        end
        else
        begin
            rem_next = trial[31:0];
            quo_next = {quo_reg[30:0], 1'b0};
        end
    end

    function automatic result_t build(input op_t op, input logic [31:0] value);
        result_t r;
        logic    cond;
        case (op.br_f3[2:1])
            CMP_EQ:  cond = (op.op_a == op.op_b);
            CMP_LT:  cond = ($signed(op.op_a) < $signed(op.op_b));
            CMP_LTU: cond = (op.op_a < op.op_b);
            default: cond = 1'b0;
        endcase
        cond = cond ^ op.br_f3[0];
        r.kind = op.kind;
        r.write_enable = op.wr;
        r.dest_index = op.rd;
        r.dest_value = op.wr ? (op.link_sel ? op.link : value) : 32'd0;
        r.branch_taken = op.jump || (op.branch && cond);
        r.next_pc = r.branch_taken ? op.target : op.seq_pc;
        r.mem_address = op.is_mem ? value : 32'd0;
        r.mem_size = op.mem_size;
        r.load_signed = op.load_signed;
        r.store_data = op.store_data;
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (in_valid && out_free)
                begin
                    if (is_mul)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (is_div)
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_MUL:
            begin
                if (out_free)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_RUN && in_valid && out_free && !is_mul && !is_div) ||
                ((state_reg == ST_MUL || state_reg == ST_FIN) && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_RUN:
            begin
                if (in_valid && out_free)
                begin
                    cur_reg <= in_op;
                    prod_reg <= in_op.op_a * in_op.op_b;
                    rem_reg <= 32'd0;
                    quo_reg <= (div_signed && in_op.op_a[31]) ? -in_op.op_a : in_op.op_a;
                    divisor_reg <= (div_signed && in_op.op_b[31]) ? -in_op.op_b : in_op.op_b;
                    cnt_reg <= 5'd0;
                    if (!is_mul && !is_div)
                    begin
                        out_reg <= build(in_op, alu_value);
                    end
                end
            end
            ST_MUL:
            begin
                if (out_free)
                begin
                    out_reg <= build(cur_reg, mul_value);
                end
            end
            ST_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_reg <= build(cur_reg, div_value);
                end
            end
            default:
            begin
                cnt_reg <= 5'd0;
            end
        endcase
    end

endmodule

@@ rtl/core/rv32im_execute_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32im_execute_unit
// Execute stage for RV32IM: decode front, item queue and execute back.
// ----------------------------------------------------------------------------
// Path: each item is registered in the queue and then in the output register;
// multiplies also pass a product register and divides the bit-serial divider.
// Throughput: one item per cycle while the output is not stalled, except
// multiply and divide, which hold the back end until their result is registered.
// Reset empties the queue, clears the output valid flag and returns the back end to its run state.
module rv32im_execute_unit
    import rvex_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // instruction, rs1_value, rs2_value, current_pc
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // write_enable, dest_index, dest_value, next_pc, branch_taken, mem_address,
    // mem_size, load_signed, store_data, zero fill
    output logic [143:0] m_axis_tdata,
    // result_kind
    output logic [2:0]   m_axis_tuser
);

    op_t     dec_op;
    op_t     q_op;
    logic    q_valid;
    logic    q_ready;
    result_t result;

    rvex_front u_front (
        .instruction (s_axis_tdata[31:0]),
        .rs1_value   (s_axis_tdata[63:32]),
        .rs2_value   (s_axis_tdata[95:64]),
        .current_pc  (s_axis_tdata[127:96]),
        .op          (dec_op)
    );

    rvex_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (dec_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op)
    );

    rvex_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_op      (q_op),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tuser = result.kind;
    assign m_axis_tdata = {6'd0, result.store_data, result.load_signed, result.mem_size,
                           result.mem_address, result.branch_taken, result.next_pc,
                           result.dest_value, result.dest_index, result.write_enable};

endmodule
